### hdl/pdsp_pkg.sv
// Shared types, codes and character constants of the PDF date string parser.
// No dependencies; every other file of the block refers to it by scoped names.
package pdsp_pkg;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic        [2:0]  status;
    logic        [13:0] year_value;
    logic        [6:0]  month_value;
    logic        [6:0]  day_value;
    logic        [6:0]  hour_value;
    logic        [6:0]  minute_value;
    logic        [6:0]  second_value;
    logic signed [19:0] offset_seconds;
  } out_t;

  typedef enum logic [1:0] {
    ZONE_NONE,
    ZONE_Z,
    ZONE_PLUS,
    ZONE_MINUS
  } zone_kind_t;

  // Result status codes; a smaller nonzero code wins.
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_LENGTH = 3'd1;
  localparam logic [2:0] ST_PREFIX = 3'd2;
  localparam logic [2:0] ST_DIGIT  = 3'd3;
  localparam logic [2:0] ST_ZONE   = 3'd4;
  localparam logic [2:0] ST_SEP    = 3'd5;

  // Bit n set: position n holds a decimal digit.
  localparam logic [31:0] DIGIT_MASK = 32'h0036_FFFC;

  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [4:0] POS_PREFIX_D     = 5'd0;
  localparam logic [4:0] POS_PREFIX_COLON = 5'd1;
  localparam logic [4:0] POS_ZONE         = 5'd16;
  localparam logic [4:0] POS_SEP          = 5'd19;
  localparam logic [4:0] POS_TRAIL        = 5'd22;
  localparam logic [4:0] POS_MAX          = 5'd31;

  localparam logic [5:0] LEN_YEAR_ONLY  = 6'd6;
  localparam logic [5:0] LEN_YEAR_MONTH = 6'd8;
  localparam logic [5:0] LEN_ZULU       = 6'd17;
  localparam logic [5:0] LEN_FULL       = 6'd23;

  localparam logic [18:0] SECS_PER_HOUR = 19'd3600;
  localparam logic [12:0] SECS_PER_MIN  = 13'd60;

  // One classified character on its way from front to back.
  typedef struct packed {
    logic [4:0] pos;
    logic       digit_en;
    logic [3:0] digit;
    zone_kind_t zone;
    logic [2:0] err;
    logic       last;
  } entry_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } queue_status_t;

  function automatic logic [2:0] merge_error(input logic [2:0] cur, input logic [2:0] e);
    if (e != ST_OK && (cur == ST_OK || e < cur)) begin
      return e;
    end
    return cur;
  endfunction

endpackage

### hdl/pdsp_front.sv
// Front end: accepts characters, tracks the position in the string and
// classifies each character into a queue entry. Depends on pdsp_pkg.
module pdsp_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  pdsp_pkg::in_t          in_data,
  input  logic                   trailing_quote_required,
  input  pdsp_pkg::queue_status_t q_status,
  output logic                   push,
  output pdsp_pkg::entry_t       push_entry
);

  logic [4:0] pos;
  logic [4:0] pos_next;
  logic       is_digit;
  logic [7:0] c;

  assign in_stall = q_status.full;
  assign push     = in_valid && !in_stall;
  assign c        = in_data.char_code;
  assign is_digit = (c >= pdsp_pkg::CH_ZERO) && (c <= pdsp_pkg::CH_NINE);

  always_comb begin
    push_entry          = '0;
    push_entry.pos      = pos;
    push_entry.last     = in_data.last_char;
    push_entry.digit_en = pdsp_pkg::DIGIT_MASK[pos] && is_digit;
    push_entry.digit    = c[3:0];
    push_entry.zone     = pdsp_pkg::ZONE_NONE;
    push_entry.err      = pdsp_pkg::ST_OK;
    case (pos)
      pdsp_pkg::POS_PREFIX_D: begin
        if (c != pdsp_pkg::CH_D) push_entry.err = pdsp_pkg::ST_PREFIX;
      end
      pdsp_pkg::POS_PREFIX_COLON: begin
        if (c != pdsp_pkg::CH_COLON) push_entry.err = pdsp_pkg::ST_PREFIX;
      end
      pdsp_pkg::POS_ZONE: begin
        if (c == pdsp_pkg::CH_Z) push_entry.zone = pdsp_pkg::ZONE_Z;
        else if (c == pdsp_pkg::CH_PLUS) push_entry.zone = pdsp_pkg::ZONE_PLUS;
        else if (c == pdsp_pkg::CH_MINUS) push_entry.zone = pdsp_pkg::ZONE_MINUS;
        else push_entry.err = pdsp_pkg::ST_ZONE;
      end
      pdsp_pkg::POS_SEP: begin
        if (c != pdsp_pkg::CH_QUOTE) push_entry.err = pdsp_pkg::ST_SEP;
      end
      pdsp_pkg::POS_TRAIL: begin
        if (trailing_quote_required && c != pdsp_pkg::CH_QUOTE) begin
          push_entry.err = pdsp_pkg::ST_SEP;
        end
      end
      default: begin
        if (pdsp_pkg::DIGIT_MASK[pos] && !is_digit) push_entry.err = pdsp_pkg::ST_DIGIT;
      end
    endcase
  end

  // Advance, saturating; restart on the last character.
  always_comb begin
    pos_next = pos;
    if (push) begin
      if (in_data.last_char) pos_next = '0;
      else if (pos != pdsp_pkg::POS_MAX) pos_next = pos + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else begin
      pos <= pos_next;
    end
  end

`ifndef SYNTH
  a_pos_restart: assert property (@(posedge clk) disable iff (rst)
    push && in_data.last_char |=> pos == 5'd0)
    else $error("position not restarted after last character");
`endif

endmodule

### hdl/pdsp_queue.sv
// Short FIFO of classified characters between front and back end.
// Depends on pdsp_pkg for the entry and status types.
module pdsp_queue #(
  parameter int DEPTH = 2
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  pdsp_pkg::entry_t        push_entry,
  input  logic                    pop,
  output pdsp_pkg::entry_t        head,
  output pdsp_pkg::queue_status_t q_status
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pdsp_pkg::entry_t slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign q_status.full      = (count == CW'(DEPTH));
  assign q_status.not_empty = (count != '0);
  assign head               = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count above depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && q_status.full))
    else $error("push into full queue");
`endif

endmodule

### hdl/pdsp_back.sv
// Back end: builds the date fields from queued characters, merges errors and
// forms the result in an output register. Depends on pdsp_pkg.
module pdsp_back (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    trailing_quote_required,
  input  pdsp_pkg::entry_t        head,
  input  pdsp_pkg::queue_status_t q_status,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output pdsp_pkg::out_t          out_data
);

  logic [13:0] year_acc, year_next;
  logic [6:0]  month_acc, month_next;
  logic [6:0]  day_acc, day_next;
  logic [6:0]  hour_acc, hour_next;
  logic [6:0]  minute_acc, minute_next;
  logic [6:0]  second_acc, second_next;
  logic [18:0] zone_hour_secs, zone_hour_secs_next;
  logic [12:0] zone_min_secs, zone_min_secs_next;
  pdsp_pkg::zone_kind_t zone_kind, zone_kind_next;
  logic [2:0]  error_code, error_code_next;
  logic [5:0]  len;
  logic [2:0]  st;
  logic [19:0] offset_mag;
  logic        out_free;
  logic        load;
  pdsp_pkg::out_t result;

  assign out_free = !out_valid || !out_stall;
  assign pop      = q_status.not_empty && (!head.last || out_free);
  assign load     = pop && head.last;

  always_comb begin
    year_next           = year_acc;
    month_next          = month_acc;
    day_next            = day_acc;
    hour_next           = hour_acc;
    minute_next         = minute_acc;
    second_next         = second_acc;
    zone_hour_secs_next = zone_hour_secs;
    zone_min_secs_next  = zone_min_secs;
    zone_kind_next      = zone_kind;
    if (head.digit_en) begin
      if (head.pos inside {[5'd2:5'd5]}) begin
        year_next = year_acc * 14'd10 + {10'd0, head.digit};
      end else if (head.pos inside {[5'd6:5'd7]}) begin
        month_next = month_acc * 7'd10 + {3'd0, head.digit};
      end else if (head.pos inside {[5'd8:5'd9]}) begin
        day_next = day_acc * 7'd10 + {3'd0, head.digit};
      end else if (head.pos inside {[5'd10:5'd11]}) begin
        hour_next = hour_acc * 7'd10 + {3'd0, head.digit};
      end else if (head.pos inside {[5'd12:5'd13]}) begin
        minute_next = minute_acc * 7'd10 + {3'd0, head.digit};
      end else if (head.pos inside {[5'd14:5'd15]}) begin
        second_next = second_acc * 7'd10 + {3'd0, head.digit};
      end else if (head.pos inside {[5'd16:5'd18]}) begin
        // zone hours kept directly in seconds
        zone_hour_secs_next = zone_hour_secs * 19'd10
                            + {15'd0, head.digit} * pdsp_pkg::SECS_PER_HOUR;
      end else begin
        zone_min_secs_next = zone_min_secs * 13'd10
                           + {9'd0, head.digit} * pdsp_pkg::SECS_PER_MIN;
      end
    end
    if (head.pos == pdsp_pkg::POS_ZONE) zone_kind_next = head.zone;
    error_code_next = pdsp_pkg::merge_error(error_code, head.err);
  end

  // Final checks and result on the last character.
  always_comb begin
    len = {1'b0, head.pos} + 6'd1;
    st  = error_code_next;
    if (len inside {[6'd0:6'd5], 6'd7, 6'd9, 6'd11, 6'd13, 6'd15, 6'd18, 6'd20,
                    6'd21, [6'd24:6'd63]}) begin
      st = pdsp_pkg::merge_error(st, pdsp_pkg::ST_LENGTH);
    end
    if (zone_kind_next == pdsp_pkg::ZONE_Z && len != pdsp_pkg::LEN_ZULU) begin
      st = pdsp_pkg::merge_error(st, pdsp_pkg::ST_ZONE);
    end
    if (trailing_quote_required) begin
      if (len < pdsp_pkg::LEN_FULL) st = pdsp_pkg::merge_error(st, pdsp_pkg::ST_SEP);
    end else begin
      if (len >= pdsp_pkg::LEN_FULL) st = pdsp_pkg::merge_error(st, pdsp_pkg::ST_SEP);
    end
    offset_mag    = {1'b0, zone_hour_secs_next} + {7'd0, zone_min_secs_next};
    result        = '0;
    result.status = st;
    if (st == pdsp_pkg::ST_OK) begin
      result.year_value   = year_next;
      result.month_value  = (len == pdsp_pkg::LEN_YEAR_ONLY) ? 7'd1 : month_next;
      result.day_value    = (len <= pdsp_pkg::LEN_YEAR_MONTH) ? 7'd1 : day_next;
      result.hour_value   = hour_next;
      result.minute_value = minute_next;
      result.second_value = second_next;
      case (zone_kind_next)
        pdsp_pkg::ZONE_PLUS:  result.offset_seconds = $signed(offset_mag);
        pdsp_pkg::ZONE_MINUS: result.offset_seconds = $signed(-offset_mag);
        default:              result.offset_seconds = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || load) begin
      year_acc       <= '0;
      month_acc      <= '0;
      day_acc        <= '0;
      hour_acc       <= '0;
      minute_acc     <= '0;
      second_acc     <= '0;
      zone_hour_secs <= '0;
      zone_min_secs  <= '0;
      zone_kind      <= pdsp_pkg::ZONE_NONE;
      error_code     <= pdsp_pkg::ST_OK;
    end else if (pop) begin
      year_acc       <= year_next;
      month_acc      <= month_next;
      day_acc        <= day_next;
      hour_acc       <= hour_next;
      minute_acc     <= minute_next;
      second_acc     <= second_next;
      zone_hour_secs <= zone_hour_secs_next;
      zone_min_secs  <= zone_min_secs_next;
      zone_kind      <= zone_kind_next;
      error_code     <= error_code_next;
    end
  end

  // Hold the result until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_data <= result;
  end

`ifndef SYNTH
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> out_free)
    else $error("result overwritten before transaction");
  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    load |=> error_code == pdsp_pkg::ST_OK && zone_kind == pdsp_pkg::ZONE_NONE)
    else $error("string state not cleared after result");
  a_error_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != pdsp_pkg::ST_OK
      |-> out_data.year_value == '0 && out_data.offset_seconds == '0)
    else $error("fields not zero on error status");
`endif

endmodule

### hdl/pdf_date_string_parser_unit.sv
// PDF date string parser, top level: one character per transaction on the
// input channel, one result per string on the output channel. It sustains one
// character per cycle while the queue has room: the front end classifies each
// character into a queue of QUEUE_DEPTH entries; the back end retires one per
// cycle, except a last character while a result waits untaken, and registers
// the result. Input stalls only on a full queue, when a result waits untaken
// and the next string's last character reaches the back end. The user must
// write the configuration register only between strings; it is not enforced.
// Depends on pdsp_pkg, pdsp_front, pdsp_queue and pdsp_back.
module pdf_date_string_parser_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  pdsp_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output pdsp_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_data
);

  logic                    trailing_quote_required;
  logic                    push;
  logic                    pop;
  pdsp_pkg::entry_t        push_entry;
  pdsp_pkg::entry_t        head;
  pdsp_pkg::queue_status_t q_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      trailing_quote_required <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      trailing_quote_required <= cfg_data;
    end
  end

  pdsp_front u_front (
    .clk                     (clk),
    .rst                     (rst),
    .in_valid                (in_valid),
    .in_stall                (in_stall),
    .in_data                 (in_data),
    .trailing_quote_required (trailing_quote_required),
    .q_status                (q_status),
    .push                    (push),
    .push_entry              (push_entry)
  );

  pdsp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_status   (q_status)
  );

  pdsp_back u_back (
    .clk                     (clk),
    .rst                     (rst),
    .trailing_quote_required (trailing_quote_required),
    .head                    (head),
    .q_status                (q_status),
    .pop                     (pop),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_data                (out_data)
  );

endmodule

### verif/pdf_date_string_parser_unit_tb.sv
// Self-checking testbench for pdf_date_string_parser_unit: directed date strings, then random
// strings in several pacing phases, each result checked against a typed or predicted date.
// Depends on pdsp_pkg and the RTL of pdf_date_string_parser_unit.
module pdf_date_string_parser_unit_tb;

  localparam int QUIET_LIMIT    = 5000;
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASE_CHARS    = 260;
  localparam int PHASES         = 6;
  localparam int PRESSURE_PHASE = 4;
  localparam int PRINT_LIMIT    = 100;

  typedef enum {PACE_FULL, PACE_SENDER_SLOW, PACE_RECEIVER_SLOW, PACE_BOTH_SLOW} pace_t;

  typedef struct {
    string          text;
    bit             quote_req;
    bit             typed;
    pdsp_pkg::out_t want;
    int             patch_pos;
    logic [7:0]     patch_val;
  } vector_row_t;

  logic           clk;
  logic           rst = 1'b1;
  logic           in_valid = 1'b0;
  logic           in_stall;
  pdsp_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  pdsp_pkg::out_t out_data;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic           cfg_data = 1'b0;

  pdf_date_string_parser_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predictor state: one date string in progress plus the quote mode.
  logic       quote_required;
  logic [4:0] char_pos;
  logic [13:0] year_sum;
  logic [6:0] month_sum, day_sum, hour_sum, minute_sum, second_sum;
  logic [6:0] zone_hour_sum, zone_minute_sum;
  pdsp_pkg::zone_kind_t zone_seen;
  logic [2:0] first_error;

  pdsp_pkg::out_t pending_dates[$];
  logic [7:0]  text_q[$];
  vector_row_t directed_rows[$];
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          send_pct = 0;
  int          stall_pct = 0;
  int          hold_request = 0;
  int          hold_left = 0;
  bit          phase_quote [PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
  pace_t       phase_pace [PHASES] = '{PACE_FULL, PACE_SENDER_SLOW, PACE_RECEIVER_SLOW,
                                       PACE_BOTH_SLOW, PACE_FULL, PACE_FULL};

  function automatic logic [2:0] lowest_error(input logic [2:0] cur, input logic [2:0] e);
    return (cur == pdsp_pkg::ST_OK || e < cur) ? e : cur;
  endfunction

  function automatic void restart_string();
    char_pos        = '0;
    year_sum        = '0;
    month_sum       = '0;
    day_sum         = '0;
    hour_sum        = '0;
    minute_sum      = '0;
    second_sum      = '0;
    zone_hour_sum   = '0;
    zone_minute_sum = '0;
    zone_seen       = pdsp_pkg::ZONE_NONE;
    first_error     = pdsp_pkg::ST_OK;
  endfunction

  // Advance the date parse by one character; returns 1 with the date on the last one.
  function automatic bit parse_char(input logic [7:0] c, input logic is_last,
                                    output pdsp_pkg::out_t res);
    logic [4:0] p;
    logic [3:0] d;
    logic [2:0] st;
    bit         is_digit;
    int         len;
    int         offset;
    p        = char_pos;
    is_digit = (c >= pdsp_pkg::CH_ZERO) && (c <= pdsp_pkg::CH_NINE);
    d        = is_digit ? 4'(c - pdsp_pkg::CH_ZERO) : 4'd0;
    res      = '0;
    if (p == pdsp_pkg::POS_PREFIX_D && c != pdsp_pkg::CH_D)
      first_error = lowest_error(first_error, pdsp_pkg::ST_PREFIX);
    if (p == pdsp_pkg::POS_PREFIX_COLON && c != pdsp_pkg::CH_COLON)
      first_error = lowest_error(first_error, pdsp_pkg::ST_PREFIX);
    if (pdsp_pkg::DIGIT_MASK[p]) begin
      if (!is_digit) first_error = lowest_error(first_error, pdsp_pkg::ST_DIGIT);
      else if (p <= 5) year_sum = 14'(year_sum * 10 + d);
      else if (p <= 7) month_sum = 7'(month_sum * 10 + d);
      else if (p <= 9) day_sum = 7'(day_sum * 10 + d);
      else if (p <= 11) hour_sum = 7'(hour_sum * 10 + d);
      else if (p <= 13) minute_sum = 7'(minute_sum * 10 + d);
      else if (p <= 15) second_sum = 7'(second_sum * 10 + d);
      else if (p <= 18) zone_hour_sum = 7'(zone_hour_sum * 10 + d);
      else zone_minute_sum = 7'(zone_minute_sum * 10 + d);
    end
    if (p == pdsp_pkg::POS_ZONE) begin
      case (c)
        pdsp_pkg::CH_Z:     zone_seen = pdsp_pkg::ZONE_Z;
        pdsp_pkg::CH_PLUS:  zone_seen = pdsp_pkg::ZONE_PLUS;
        pdsp_pkg::CH_MINUS: zone_seen = pdsp_pkg::ZONE_MINUS;
        default:  first_error = lowest_error(first_error, pdsp_pkg::ST_ZONE);
      endcase
    end
    if (p == pdsp_pkg::POS_SEP && c != pdsp_pkg::CH_QUOTE)
      first_error = lowest_error(first_error, pdsp_pkg::ST_SEP);
    if (p == pdsp_pkg::POS_TRAIL && quote_required && c != pdsp_pkg::CH_QUOTE)
      first_error = lowest_error(first_error, pdsp_pkg::ST_SEP);
    if (!is_last) begin
      if (char_pos != pdsp_pkg::POS_MAX) char_pos = char_pos + 5'd1;
      return 1'b0;
    end
    len = int'(p) + 1;
    st  = first_error;
    if (!(len inside {6, 8, 10, 12, 14, 16, 17, 19, 22, 23}))
      st = lowest_error(st, pdsp_pkg::ST_LENGTH);
    if (zone_seen == pdsp_pkg::ZONE_Z && len != pdsp_pkg::LEN_ZULU)
      st = lowest_error(st, pdsp_pkg::ST_ZONE);
    if (quote_required ? (len < pdsp_pkg::LEN_FULL) : (len >= pdsp_pkg::LEN_FULL))
      st = lowest_error(st, pdsp_pkg::ST_SEP);
    res.status = st;
    if (st == pdsp_pkg::ST_OK) begin
      res.year_value   = year_sum;
      res.month_value  = (len == pdsp_pkg::LEN_YEAR_ONLY) ? 7'd1 : month_sum;
      res.day_value    = (len <= pdsp_pkg::LEN_YEAR_MONTH) ? 7'd1 : day_sum;
      res.hour_value   = hour_sum;
      res.minute_value = minute_sum;
      res.second_value = second_sum;
      offset = 0;
      if (zone_seen == pdsp_pkg::ZONE_PLUS || zone_seen == pdsp_pkg::ZONE_MINUS)
        offset = (int'(zone_hour_sum) * 60 + int'(zone_minute_sum)) * 60;
      if (zone_seen == pdsp_pkg::ZONE_MINUS) offset = -offset;
      res.offset_seconds = 20'(offset);
    end
    restart_string();
    return 1'b1;
  endfunction

  function automatic pdsp_pkg::out_t parsed_date(int y, int mo, int dy, int h, int mi, int s,
                                                 int off);
    pdsp_pkg::out_t r;
    r = '0;
    r.status         = pdsp_pkg::ST_OK;
    r.year_value     = 14'(y);
    r.month_value    = 7'(mo);
    r.day_value      = 7'(dy);
    r.hour_value     = 7'(h);
    r.minute_value   = 7'(mi);
    r.second_value   = 7'(s);
    r.offset_seconds = 20'(off);
    return r;
  endfunction

  function automatic pdsp_pkg::out_t rejected(logic [2:0] st);
    pdsp_pkg::out_t r;
    r = '0;
    r.status = st;
    return r;
  endfunction

  function automatic void add_row(string text, bit quote_req, bit typed = 1'b0,
                                  pdsp_pkg::out_t want = '0,
                                  int patch_pos = -1, logic [7:0] patch_val = 8'h00);
    vector_row_t row;
    row.text      = text;
    row.quote_req = quote_req;
    row.typed     = typed;
    row.want      = want;
    row.patch_pos = patch_pos;
    row.patch_val = patch_val;
    directed_rows.push_back(row);
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic signed [31:0] got, logic signed [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // Result checker, receiver stall and watchdog; all handshakes use pre-edge values.
  always @(posedge clk) begin
    pdsp_pkg::out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_dates.size() == 0) begin
        report_mismatch($sformatf("result with no string pending, status %0d", out_data.status));
      end else begin
        want = pending_dates.pop_front();
        check_field("status", out_data.status, want.status);
        check_field("year", out_data.year_value, want.year_value);
        check_field("month", out_data.month_value, want.month_value);
        check_field("day", out_data.day_value, want.day_value);
        check_field("hour", out_data.hour_value, want.hour_value);
        check_field("minute", out_data.minute_value, want.minute_value);
        check_field("second", out_data.second_value, want.second_value);
        check_field("offset", $signed(out_data.offset_seconds), $signed(want.offset_seconds));
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("pdf_date_string_parser_unit_tb: done, errors");
      $finish;
    end
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Send text_q as one string; each accepted transaction advances the predictor.
  task automatic send_text(bit typed, pdsp_pkg::out_t want);
    pdsp_pkg::out_t res;
    int   i;
    int   gap;
    logic is_last;
    for (i = 0; i < text_q.size(); i++) begin
      is_last = (i == text_q.size() - 1);
      gap = 0;
      while ($urandom_range(0, 99) < send_pct) gap++;
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data  <= '{char_code: text_q[i], last_char: is_last};
      @(posedge clk);
      while (in_stall !== 1'b0) @(posedge clk);
      if (parse_char(text_q[i], is_last, res)) pending_dates.push_back(typed ? want : res);
    end
  endtask

  // Drain all pending dates, let the pipeline settle, then write the quote mode.
  task automatic write_quote_mode(bit mode);
    in_valid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
    quote_required = mode;
  endtask

  // Mostly well-formed dates with random digits and zone, some corrupted, some pure noise.
  task automatic make_random_text(bit quote_req);
    int kind;
    int len;
    int n;
    int i;
    int zone;
    int accepted_lens[10] = '{6, 8, 10, 12, 14, 16, 17, 19, 22, 23};
    text_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      n = $urandom_range(1, 40);
      repeat (n) text_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    len = (quote_req && $urandom_range(0, 1) == 1) ? 23 : accepted_lens[$urandom_range(0, 9)];
    zone = (len == pdsp_pkg::LEN_ZULU || $urandom_range(0, 9) == 0) ? $urandom_range(0, 2)
                                                                   : $urandom_range(1, 2);
    text_q.push_back(pdsp_pkg::CH_D);
    text_q.push_back(pdsp_pkg::CH_COLON);
    for (i = 2; i < 23; i++) begin
      if (i == pdsp_pkg::POS_ZONE)
        text_q.push_back(zone == 0 ? pdsp_pkg::CH_Z
                                   : (zone == 1 ? pdsp_pkg::CH_PLUS : pdsp_pkg::CH_MINUS));
      else if (i == pdsp_pkg::POS_SEP || i == pdsp_pkg::POS_TRAIL)
        text_q.push_back(pdsp_pkg::CH_QUOTE);
      else
        text_q.push_back(8'(pdsp_pkg::CH_ZERO + $urandom_range(0, 9)));
    end
    while (text_q.size() > len) void'(text_q.pop_back());
    if (kind < 30) begin
      text_q[$urandom_range(0, len - 1)] = 8'($urandom_range(0, 255));
    end else if (kind < 40) begin
      n = $urandom_range(1, 40);
      while (text_q.size() > n) void'(text_q.pop_back());
      while (text_q.size() < n) text_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int i;
    int ph;
    int chars;
    int cur_mode;
    cur_mode = -1;
    quote_required = 1'b0;
    restart_string();

    add_row("D:2024", 1'b0, 1'b1, parsed_date(2024, 1, 1, 0, 0, 0, 0));
    add_row("D:0000", 1'b0, 1'b1, parsed_date(0, 1, 1, 0, 0, 0, 0));
    add_row("D:99999999999999", 1'b0, 1'b1, parsed_date(9999, 99, 99, 99, 99, 99, 0));
    add_row("D:202401", 1'b0);
    add_row("D:20240131", 1'b0);
    add_row("D:20240229235959Z", 1'b0);
    add_row("D:20240229235959+", 1'b0);
    add_row("D:20240101120000+05", 1'b0);
    add_row("D:19991231235959+05'30", 1'b0);
    add_row("D:19991231235959-99'99", 1'b0, 1'b1,
            parsed_date(1999, 12, 31, 23, 59, 59, -362340));
    add_row("D", 1'b0, 1'b1, rejected(pdsp_pkg::ST_LENGTH));
    add_row("X:2024", 1'b0, 1'b1, rejected(pdsp_pkg::ST_PREFIX));
    add_row("D:20a4", 1'b0, 1'b1, rejected(pdsp_pkg::ST_DIGIT));
    add_row("D:20240101120000X", 1'b0, 1'b1, rejected(pdsp_pkg::ST_ZONE));
    add_row("D:20240101120000Z00'00", 1'b0, 1'b1, rejected(pdsp_pkg::ST_ZONE));
    add_row("D:20240101120000+05:00", 1'b0, 1'b1, rejected(pdsp_pkg::ST_SEP));
    add_row("D:20240101120000+05'00'", 1'b0, 1'b1, rejected(pdsp_pkg::ST_SEP));
    add_row("D:20240101120000+05'00'x", 1'b0, 1'b1, rejected(pdsp_pkg::ST_LENGTH));
    add_row("D:2024X", 1'b0, 1'b1, rejected(pdsp_pkg::ST_LENGTH));
    add_row("D:20240101120000+05'00'00000000000000000", 1'b0, 1'b1,
            rejected(pdsp_pkg::ST_LENGTH));
    add_row("D:2024", 1'b0, 1'b1, rejected(pdsp_pkg::ST_DIGIT), 5, 8'hFF);
    add_row("D:2024", 1'b0, 1'b1, rejected(pdsp_pkg::ST_PREFIX), 0, 8'h00);
    add_row("D:20240101120000+05'00'", 1'b1);
    add_row("D:20240101120000-11'45'", 1'b1);
    add_row("D:20240101120000+05'00", 1'b1, 1'b1, rejected(pdsp_pkg::ST_SEP));
    add_row("D:20240101120000+05'00x", 1'b1, 1'b1, rejected(pdsp_pkg::ST_SEP));
    add_row("D:2024", 1'b1, 1'b1, rejected(pdsp_pkg::ST_SEP));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k]) begin
      if (int'(directed_rows[k].quote_req) != cur_mode) begin
        write_quote_mode(directed_rows[k].quote_req);
        cur_mode = directed_rows[k].quote_req;
      end
      text_q.delete();
      for (i = 0; i < directed_rows[k].text.len(); i++)
        text_q.push_back(directed_rows[k].text[i]);
      if (directed_rows[k].patch_pos >= 0)
        text_q[directed_rows[k].patch_pos] = directed_rows[k].patch_val;
      send_text(directed_rows[k].typed, directed_rows[k].want);
    end

    for (ph = 0; ph < PHASES; ph++) begin
      write_quote_mode(phase_quote[ph]);
      case (phase_pace[ph])
        PACE_SENDER_SLOW:   begin send_pct = 86; stall_pct = 0;  end
        PACE_RECEIVER_SLOW: begin send_pct = 0;  stall_pct = 86; end
        PACE_BOTH_SLOW:     begin send_pct = 33; stall_pct = 33; end
        default:            begin send_pct = 0;  stall_pct = 0;  end
      endcase
      // Hold the output long enough for the input side to back up.
      if (ph == PRESSURE_PHASE) hold_request = HOLD_CYCLES;
      chars = 0;
      while (chars < PHASE_CHARS) begin
        make_random_text(phase_quote[ph]);
        chars += text_q.size();
        send_text(1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("pdf_date_string_parser_unit_tb: done, clean");
    end else begin
      $display("pdf_date_string_parser_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

### sim.f
hdl/pdsp_pkg.sv
hdl/pdsp_front.sv
hdl/pdsp_queue.sv
hdl/pdsp_back.sv
hdl/pdf_date_string_parser_unit.sv
verif/pdf_date_string_parser_unit_tb.sv
